// File: rtl/core/spq_pkg.sv
`default_nettype none

package spq_pkg;

  localparam int unsigned TimeW = 16;
  localparam logic [TimeW-1:0] TimeMax = {TimeW{1'b1}};

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_TICK   = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  // broadcast to every cell for one step
  typedef struct packed {
    logic ins;
    logic rem;
    logic tick;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/core/sorted_priority_queue_with_ageing_unit.sv
// Sorted priority queue with ageing, built as a row of DEPTH cells.
// Request channel: in_valid_i/in_ready_o carry op_i (insert, remove lowest,
// tick), priority_req_i, tag_i and start_time_i. Each request gives exactly one
// result on out_valid_o/out_ready_i: the removed entry (item_valid_o with
// tag, priority and time), full_error_o for a dropped insert, and the fill
// state after the request (is_empty_o, entry_count_o).
// All cells update in parallel on each accepted request, each looking
// only at its two neighbors and the broadcast request, so one request is
// accepted per cycle while in_ready_o is high and its result shows in the
// output register on the next cycle.
// A full output register that is not taken holds in_ready_o low; a result
// taken in the same cycle frees the register for the next request, so
// throughput stays one request per cycle while the receiver keeps up.
// Reset empties the queue and the output register; entry storage itself
// is not cleared, only the per-cell used flags.
`default_nettype none

module sorted_priority_queue_with_ageing_unit #(
  parameter int unsigned DEPTH         = 16,
  parameter int unsigned PRIORITY_BITS = 16,
  parameter int unsigned TAG_BITS      = 8
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                in_valid_i,
  output logic                               in_ready_o,
  input  wire [1:0]                          op_i,
  input  wire [PRIORITY_BITS-1:0]            priority_req_i,
  input  wire [TAG_BITS-1:0]                 tag_i,
  input  wire [spq_pkg::TimeW-1:0]           start_time_i,
  output logic                               out_valid_o,
  input  wire                                out_ready_i,
  output logic                               item_valid_o,
  output logic [TAG_BITS-1:0]                out_tag_o,
  output logic [PRIORITY_BITS-1:0]           out_priority_o,
  output logic [spq_pkg::TimeW-1:0]          out_time_o,
  output logic                               full_error_o,
  output logic                               is_empty_o,
  output logic [$clog2(DEPTH+1)-1:0]         entry_count_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [DEPTH-1:0]          used;
  logic [DEPTH-1:0]          keep;
  logic [PRIORITY_BITS-1:0]  prio [DEPTH];
  logic [TAG_BITS-1:0]       tag  [DEPTH];
  logic [spq_pkg::TimeW-1:0] tim  [DEPTH];

  logic [CntW-1:0] count_q, count_d;
  logic            accept, full, empty;
  spq_pkg::cell_ctrl_t ctrl;
  spq_pkg::op_e        op;

  logic                      out_valid_q, out_valid_d;
  logic                      item_valid_q, full_error_q;
  logic [TAG_BITS-1:0]       out_tag_q;
  logic [PRIORITY_BITS-1:0]  out_prio_q;
  logic [spq_pkg::TimeW-1:0] out_time_q;
  logic [CntW-1:0]           out_count_q;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign op         = spq_pkg::op_e'(op_i);
  assign full       = (count_q == CntW'(DEPTH));
  assign empty      = (count_q == '0);

  always_comb begin
    ctrl    = '0;
    count_d = count_q;
    if (accept) begin
      unique case (op)
        spq_pkg::OP_INSERT: begin
          if (!full) begin
            ctrl.ins = 1'b1;
            count_d  = count_q + CntW'(1);
          end
        end
        spq_pkg::OP_REMOVE: begin
          if (!empty) begin
            ctrl.rem = 1'b1;
            count_d  = count_q - CntW'(1);
          end
        end
        spq_pkg::OP_TICK: ctrl.tick = 1'b1;
        spq_pkg::OP_NONE: ;
        default: ;
      endcase
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                      l_used, l_keep, r_used;
    logic [PRIORITY_BITS-1:0]  l_prio, r_prio;
    logic [TAG_BITS-1:0]       l_tag, r_tag;
    logic [spq_pkg::TimeW-1:0] l_time, r_time;

    if (i == 0) begin : g_first
      // head cell takes the new entry whenever it does not keep its own
      assign l_used = 1'b0;
      assign l_keep = 1'b1;
      assign l_prio = '0;
      assign l_tag  = '0;
      assign l_time = '0;
    end else begin : g_mid
      assign l_used = used[i-1];
      assign l_keep = keep[i-1];
      assign l_prio = prio[i-1];
      assign l_tag  = tag[i-1];
      assign l_time = tim[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign r_used = 1'b0;
      assign r_prio = '0;
      assign r_tag  = '0;
      assign r_time = '0;
    end else begin : g_inner
      assign r_used = used[i+1];
      assign r_prio = prio[i+1];
      assign r_tag  = tag[i+1];
      assign r_time = tim[i+1];
    end

    spq_cell #(
      .PRIORITY_BITS(PRIORITY_BITS),
      .TAG_BITS     (TAG_BITS)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .ins_prio_i  (priority_req_i),
      .ins_tag_i   (tag_i),
      .ins_time_i  (start_time_i),
      .left_used_i (l_used),
      .left_keep_i (l_keep),
      .left_prio_i (l_prio),
      .left_tag_i  (l_tag),
      .left_time_i (l_time),
      .right_used_i(r_used),
      .right_prio_i(r_prio),
      .right_tag_i (r_tag),
      .right_time_i(r_time),
      .used_o      (used[i]),
      .keep_o      (keep[i]),
      .prio_o      (prio[i]),
      .tag_o       (tag[i]),
      .time_o      (tim[i])
    );
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_valid_q <= ctrl.rem;
      full_error_q <= (op == spq_pkg::OP_INSERT) && full;
      out_tag_q    <= ctrl.rem ? tag[0]  : '0;
      out_prio_q   <= ctrl.rem ? prio[0] : '0;
      out_time_q   <= ctrl.rem ? tim[0]  : '0;
      out_count_q  <= count_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign item_valid_o   = item_valid_q;
  assign full_error_o   = full_error_q;
  assign out_tag_o      = out_tag_q;
  assign out_priority_o = out_prio_q;
  assign out_time_o     = out_time_q;
  assign entry_count_o  = out_count_q;
  assign is_empty_o     = (out_count_q == '0);

`ifndef NO_ASSERTIONS
  a_used_matches_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(used) == int'(count_q))
    else $error("cell used flags disagree with entry count");

  a_full_error_at_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && full_error_q |-> out_count_q == CntW'(DEPTH))
    else $error("full error reported below depth");

  a_remove_or_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(item_valid_q && full_error_q))
    else $error("remove and dropped insert in one result");

  a_remove_decrements: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (op == spq_pkg::OP_REMOVE) && !empty |=>
      count_q == $past(count_q) - CntW'(1))
    else $error("remove did not shrink the queue");
`endif

endmodule

`default_nettype wire

// File: rtl/core/spq_cell.sv
`default_nettype none

module spq_cell #(
  parameter int unsigned PRIORITY_BITS = 16,
  parameter int unsigned TAG_BITS      = 8
) (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  spq_pkg::cell_ctrl_t             ctrl_i,
  input  wire [PRIORITY_BITS-1:0]         ins_prio_i,
  input  wire [TAG_BITS-1:0]              ins_tag_i,
  input  wire [spq_pkg::TimeW-1:0]        ins_time_i,
  input  wire                             left_used_i,
  input  wire                             left_keep_i,
  input  wire [PRIORITY_BITS-1:0]         left_prio_i,
  input  wire [TAG_BITS-1:0]              left_tag_i,
  input  wire [spq_pkg::TimeW-1:0]        left_time_i,
  input  wire                             right_used_i,
  input  wire [PRIORITY_BITS-1:0]         right_prio_i,
  input  wire [TAG_BITS-1:0]              right_tag_i,
  input  wire [spq_pkg::TimeW-1:0]        right_time_i,
  output logic                            used_o,
  output logic                            keep_o,
  output logic [PRIORITY_BITS-1:0]        prio_o,
  output logic [TAG_BITS-1:0]             tag_o,
  output logic [spq_pkg::TimeW-1:0]       time_o
);

  logic                      used_q, used_d;
  logic [PRIORITY_BITS-1:0]  prio_q, prio_d;
  logic [TAG_BITS-1:0]       tag_q, tag_d;
  logic [spq_pkg::TimeW-1:0] time_q, time_d;
  logic                      keep;

  // entry stays put on insert when it sorts before or ties with the new one
  assign keep = used_q && (prio_q <= ins_prio_i);

  always_comb begin
    used_d = used_q;
    prio_d = prio_q;
    tag_d  = tag_q;
    time_d = time_q;
    if (ctrl_i.ins) begin
      if (!keep) begin
        if (left_keep_i) begin
          used_d = 1'b1;
          prio_d = ins_prio_i;
          tag_d  = ins_tag_i;
          time_d = ins_time_i;
        end else begin
          used_d = left_used_i;
          prio_d = left_prio_i;
          tag_d  = left_tag_i;
          time_d = left_time_i;
        end
      end
    end else if (ctrl_i.rem) begin
      used_d = right_used_i;
      prio_d = right_prio_i;
      tag_d  = right_tag_i;
      time_d = right_time_i;
    end else if (ctrl_i.tick) begin
      if (used_q && (time_q != spq_pkg::TimeMax)) begin
        time_d = time_q + spq_pkg::TimeW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= 1'b0;
    end else begin
      used_q <= used_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prio_q <= prio_d;
    tag_q  <= tag_d;
    time_q <= time_d;
  end

  assign used_o = used_q;
  assign keep_o = keep;
  assign prio_o = prio_q;
  assign tag_o  = tag_q;
  assign time_o = time_q;

endmodule

`default_nettype wire
